>>> rtl/tbac_pkg.sv
// Package for the thread budget admission controller.
// Holds shared constants, the slot entry type and the free-room function.
// No dependencies.
package tbac_pkg;

  localparam int unsigned SlotBits = 6;
  localparam int unsigned Slots    = 1 << SlotBits;

  localparam logic [1:0] ModeConnect    = 2'd0;
  localparam logic [1:0] ModeMessage    = 2'd1;
  localparam logic [1:0] ModeDisconnect = 2'd2;
  localparam logic [1:0] ModePending    = 2'd3;

  localparam logic [7:0] CmdStarted = 8'd1;
  localparam logic [7:0] CmdAdded   = 8'd2;
  localparam logic [7:0] CmdRemoved = 8'd3;

  localparam logic [1:0] StRunning = 2'd1;
  localparam logic [1:0] StSuspend = 2'd2;
  localparam logic [1:0] StWaiting = 2'd3;

  localparam logic [1:0] CfgThreadLimit = 2'd0;
  localparam logic [1:0] CfgFailLimit   = 2'd1;
  localparam logic [1:0] CfgSampleShift = 2'd2;

  localparam logic [15:0] ThreadLimitReset = 16'd5000;
  localparam logic [7:0]  FailLimitReset   = 8'd10;
  localparam logic [3:0]  SampleShiftReset = 4'd4;

  // One slot table entry as stored in memory.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] threads;
    logic [7:0]  failures;
  } slot_entry_t;

  // Free room in samples: (limit - total - (launched << shift)) >> shift, floored at 0.
  function automatic logic [16:0] room_samples(input logic [15:0] limit,
                                               input logic [15:0] total,
                                               input logic [15:0] launched,
                                               input logic [3:0]  shift);
    logic [31:0]        shl;
    logic signed [33:0] diff;
    logic [33:0]        shr;
    shl  = {16'd0, launched} << shift;
    diff = $signed({18'd0, limit}) - $signed({18'd0, total}) - $signed({2'b00, shl});
    shr  = $unsigned(diff) >> shift;
    if (diff <= 34'sd0) begin
      return 17'd0;
    end
    return shr[16:0];
  endfunction

endpackage

>>> rtl/tbac_used_vec.sv
// Slot occupancy bits for the admission controller.
// Depends on tbac_pkg; one flip-flop per slot, cleared by reset.
module tbac_used_vec (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         set_i,
  input  logic                         clr_i,
  input  logic [tbac_pkg::SlotBits-1:0] wr_slot_i,
  input  logic [tbac_pkg::SlotBits-1:0] rd_slot_i,
  output logic                         rd_used_o,
  output logic                         any_used_o
);

  logic [tbac_pkg::Slots-1:0] used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (set_i) begin
      used_q[wr_slot_i] <= 1'b1;
    end else if (clr_i) begin
      used_q[wr_slot_i] <= 1'b0;
    end
  end

  assign rd_used_o  = used_q[rd_slot_i];
  assign any_used_o = |used_q;

endmodule

>>> rtl/thread_budget_admission_controller.sv
// Thread budget admission controller: one event per request, one result each.
// A connect or plain message goes from the event step to the result strobe, a pending
// report passes the launch step first, and a table scan adds to that, or two when a
// message suspends a client; each scan step reads one entry of the single-port memory.
// busy stays high through the strobe; the next request is taken in the cycle after it.
// Reset clears occupancy and counters, resets configuration; results never stall.
module thread_budget_admission_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic [1:0]  mode_i,
  input  logic [5:0]  slot_i,
  input  logic [7:0]  command_i,
  input  logic [15:0] pending_count_i,
  output logic        done_o,
  output logic        suspend_valid_o,
  output logic [5:0]  suspend_slot_o,
  output logic        resume_valid_o,
  output logic [5:0]  resume_slot_o,
  output logic [15:0] launch_count_o,
  output logic [15:0] thread_total_o
);

  localparam int unsigned SB = tbac_pkg::SlotBits;

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_RDEV   = 10'b0000000010,  // event slot read issued
    S_EVENT  = 10'b0000000100,  // apply event to entry
    S_MXRD   = 10'b0000001000,  // max-running scan read
    S_MXCHK  = 10'b0000010000,
    S_SUSP   = 10'b0000100000,  // suspend chosen slot
    S_RSRD   = 10'b0001000000,  // resume scan read
    S_RSCHK  = 10'b0010000000,
    S_LAUNCH = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] thr_lim_q;
  logic [7:0]  fail_lim_q;
  logic [3:0]  shift_q;

  // Global counters.
  logic [15:0] total_q, total_d;
  logic [15:0] pend_q, pend_d;
  logic [15:0] launched_q, launched_d;

  // Request capture.
  logic [1:0]    mode_q;
  logic [SB-1:0] slot_q;
  logic [7:0]    cmd_q;
  logic [15:0]   cnt_q;
  logic          skip_q, skip_d;

  // Scan control.
  logic [SB:0]   idx_q, idx_d;
  logic          best_v_q, best_v_d;
  logic [SB-1:0] best_q, best_d;
  logic [15:0]   best_thr_q, best_thr_d;

  // Result registers.
  logic          sus_v_q, sus_v_d;
  logic [SB-1:0] sus_s_q, sus_s_d;
  logic          res_v_q, res_v_d;
  logic [SB-1:0] res_s_q, res_s_d;
  logic [15:0]   launch_q, launch_d;

  // Slot memory, one synchronous port.
  tbac_pkg::slot_entry_t mem [tbac_pkg::Slots];
  tbac_pkg::slot_entry_t rd_q;
  logic                  mem_re, mem_we;
  logic [SB-1:0]         mem_addr;
  tbac_pkg::slot_entry_t mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  // Occupancy bits.
  logic          used_set, used_clr, used_rd, any_used;
  logic [SB-1:0] used_rd_slot;

  tbac_used_vec u_used (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .set_i      (used_set),
    .clr_i      (used_clr),
    .wr_slot_i  (slot_q),
    .rd_slot_i  (used_rd_slot),
    .rd_used_o  (used_rd),
    .any_used_o (any_used)
  );

  logic        accept;
  logic [16:0] room;
  logic [16:0] idle;
  logic [SB-1:0] idx_s;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign room   = tbac_pkg::room_samples(thr_lim_q, total_q, launched_q, shift_q);
  assign idle   = (thr_lim_q > total_q) ? {1'b0, thr_lim_q - total_q} : 17'd0;
  assign idx_s  = idx_q[SB-1:0];

  // Look up occupancy of the scanned slot during a scan, else of the event slot.
  assign used_rd_slot = (state_q == S_MXCHK || state_q == S_RSCHK) ? idx_s : slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_lim_q  <= tbac_pkg::ThreadLimitReset;
      fail_lim_q <= tbac_pkg::FailLimitReset;
      shift_q    <= tbac_pkg::SampleShiftReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tbac_pkg::CfgThreadLimit: thr_lim_q  <= cfg_data_i;
        tbac_pkg::CfgFailLimit:   fail_lim_q <= cfg_data_i[7:0];
        tbac_pkg::CfgSampleShift: shift_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      total_q    <= '0;
      pend_q     <= '0;
      launched_q <= '0;
    end else begin
      state_q    <= state_d;
      total_q    <= total_d;
      pend_q     <= pend_d;
      launched_q <= launched_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      slot_q <= slot_i;
      cmd_q  <= command_i;
      cnt_q  <= pending_count_i;
    end
    skip_q     <= skip_d;
    idx_q      <= idx_d;
    best_v_q   <= best_v_d;
    best_q     <= best_d;
    best_thr_q <= best_thr_d;
    sus_v_q    <= sus_v_d;
    sus_s_q    <= sus_s_d;
    res_v_q    <= res_v_d;
    res_s_q    <= res_s_d;
    launch_q   <= launch_d;
  end

  always_comb begin
    logic [16:0]  lsum;
    logic [15:0]  m;
    logic [16:0]  tsum;
    logic [7:0]   fail_n;
    logic         present;
    logic         suspended;
    tbac_pkg::slot_entry_t e;
    state_d      = state_q;
    total_d      = total_q;
    pend_d       = pend_q;
    launched_d   = launched_q;
    skip_d       = skip_q;
    idx_d        = idx_q;
    best_v_d     = best_v_q;
    best_d       = best_q;
    best_thr_d   = best_thr_q;
    sus_v_d      = sus_v_q;
    sus_s_d      = sus_s_q;
    res_v_d      = res_v_q;
    res_s_d      = res_s_q;
    launch_d     = launch_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = slot_q;
    mem_wdata    = rd_q;
    used_set     = 1'b0;
    used_clr     = 1'b0;
    present      = used_rd;
    e            = rd_q;
    lsum         = '0;
    m            = '0;
    tsum         = '0;
    fail_n       = '0;
    suspended    = 1'b0;
    done_o       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          sus_v_d  = 1'b0;
          sus_s_d  = '0;
          res_v_d  = 1'b0;
          res_s_d  = '0;
          launch_d = '0;
          mem_re   = 1'b1;
          mem_addr = slot_i;
          state_d  = S_RDEV;
        end
      end
      S_RDEV: begin
        state_d = S_EVENT;
      end
      S_EVENT: begin
        idx_d    = '0;
        best_v_d = 1'b0;
        skip_d   = 1'b0;
        case (mode_q)
          tbac_pkg::ModeConnect: begin
            used_set         = 1'b1;
            mem_we           = 1'b1;
            mem_wdata.status = tbac_pkg::StWaiting;
            mem_wdata.threads  = '0;
            mem_wdata.failures = '0;
            if (launched_q != '0) launched_d = launched_q - 16'd1;
            state_d = S_DONE;
          end
          tbac_pkg::ModeMessage: begin
            tsum = {1'b0, total_q};
            if (present) begin
              if (cmd_q == tbac_pkg::CmdStarted) begin
                e.status = tbac_pkg::StRunning;
              end else if (cmd_q == tbac_pkg::CmdAdded && e.threads != 16'hFFFF) begin
                e.threads = e.threads + 16'd1;
                if (e.status != tbac_pkg::StSuspend && total_q != 16'hFFFF)
                  tsum = {1'b0, total_q} + 17'd1;
              end else if (cmd_q == tbac_pkg::CmdRemoved && e.threads != '0) begin
                e.threads = e.threads - 16'd1;
                if (e.status != tbac_pkg::StSuspend && total_q != '0)
                  tsum = {1'b0, total_q} - 17'd1;
              end
              mem_we    = 1'b1;
              mem_wdata = e;
            end
            total_d = tsum[15:0];
            if (tsum[15:0] > thr_lim_q) begin
              state_d = S_MXRD;
            end else if (tbac_pkg::room_samples(thr_lim_q, tsum[15:0], launched_q,
                                               shift_q) != '0) begin
              state_d = S_RSRD;
            end else begin
              state_d = S_DONE;
            end
          end
          tbac_pkg::ModeDisconnect: begin
            if (present) begin
              used_clr = 1'b1;
              if (e.status != tbac_pkg::StSuspend)
                total_d = (total_q > e.threads) ? total_q - e.threads : '0;
            end
            state_d = S_LAUNCH;  // resolve "any used" next cycle, then scan
          end
          default: begin
            pend_d  = cnt_q;
            state_d = S_LAUNCH;
          end
        endcase
      end
      S_MXRD: begin
        mem_re   = 1'b1;
        mem_addr = idx_s;
        state_d  = S_MXCHK;
      end
      S_MXCHK: begin
        if (used_rd && rd_q.status == tbac_pkg::StRunning &&
            (!best_v_q || rd_q.threads > best_thr_q)) begin
          best_v_d   = 1'b1;
          best_d     = idx_s;
          best_thr_d = rd_q.threads;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == (SB+1)'(tbac_pkg::Slots - 1)) begin
          state_d = (best_v_q || (used_rd && rd_q.status == tbac_pkg::StRunning))
                    ? S_SUSP : S_DONE;
          if (state_d == S_SUSP) mem_re = 1'b1;
          mem_addr = best_v_d ? best_d : idx_s;
        end else begin
          state_d = S_MXRD;
        end
      end
      S_SUSP: begin
        // rd_q holds the chosen entry here.
        mem_addr         = best_q;
        mem_we           = 1'b1;
        mem_wdata.status = tbac_pkg::StSuspend;
        total_d  = (total_q > best_thr_q) ? total_q - best_thr_q : '0;
        sus_v_d  = 1'b1;
        sus_s_d  = best_q;
        skip_d   = 1'b1;
        idx_d    = '0;
        state_d  = S_RSRD;
      end
      S_RSRD: begin
        mem_re   = 1'b1;
        mem_addr = idx_s;
        state_d  = S_RSCHK;
      end
      S_RSCHK: begin
        mem_addr     = idx_s;
        suspended    = used_rd && rd_q.status == tbac_pkg::StSuspend &&
                       !(skip_q && idx_s == slot_q);
        if (suspended && {1'b0, rd_q.threads} < idle) begin
          mem_we             = 1'b1;
          mem_wdata.status   = tbac_pkg::StRunning;
          mem_wdata.failures = '0;
          tsum    = {1'b0, total_q} + {1'b0, rd_q.threads};
          total_d = tsum[16] ? 16'hFFFF : tsum[15:0];
          res_v_d = 1'b1;
          res_s_d = idx_s;
          state_d = S_DONE;
        end else begin
          fail_n = rd_q.failures;
          if (suspended) begin
            if (fail_n != 8'hFF) fail_n = fail_n + 8'd1;
            mem_we             = 1'b1;
            mem_wdata.failures = fail_n;
          end
          idx_d = idx_q + 1'b1;
          if (suspended && fail_n > fail_lim_q) begin
            state_d = S_DONE;
          end else if (idx_q == (SB+1)'(tbac_pkg::Slots - 1)) begin
            state_d = S_LAUNCH;
            skip_d  = 1'b1;   // mark scan finished
          end else begin
            state_d = S_RSRD;
          end
        end
      end
      S_LAUNCH: begin
        if (mode_q == tbac_pkg::ModeDisconnect && !skip_q) begin
          // Disconnect: clear total if table empty, then scan.
          if (!any_used) total_d = '0;
          skip_d  = 1'b0;
          idx_d   = '0;
          state_d = S_RSRD;
        end else begin
          if (pend_q != '0 && room != '0) begin
            m          = (room < {1'b0, pend_q}) ? room[15:0] : pend_q;
            lsum       = {1'b0, launched_q} + {1'b0, m};
            launched_d = lsum[16] ? 16'hFFFF : lsum[15:0];
            pend_d     = pend_q - m;
            launch_d   = m;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign suspend_valid_o = sus_v_q;
  assign suspend_slot_o  = sus_s_q;
  assign resume_valid_o  = res_v_q;
  assign resume_slot_o   = res_s_q;
  assign launch_count_o  = launch_q;
  assign thread_total_o  = total_q;

`ifndef NO_ASSERTIONS
  // A result strobe closes every request and is only one cycle long.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done strobe longer than one cycle");
  // A request is never taken while one is in flight.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && busy) |=> (state_q != S_RDEV)) else $error("request taken while busy");
  // Slot fields are zero when their valid bit is low.
  a_sus_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !suspend_valid_o) |-> (suspend_slot_o == '0)) else $error("stray suspend slot");
  a_res_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !resume_valid_o) |-> (resume_slot_o == '0)) else $error("stray resume slot");
`endif

endmodule
